// File: rtl/pressure_to_altitude_top_defines.svh
// ----------------------------------------------------------------------------
// Pressure to altitude: assertion macros
// Concurrent checks on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TO_ALTITUDE_TOP_DEFINES_SVH
`define PRESSURE_TO_ALTITUDE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define P2A_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("p2a: assertion failed");
// next-cycle implication
`define P2A_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("p2a: assertion failed");
`else
`define P2A_ASSERT_IMP(lbl, ante, cons)
`define P2A_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/p2a_pkg.sv
// ----------------------------------------------------------------------------
// p2a_pkg
// Shared widths, constants and constant functions of the altitude pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package p2a_pkg;

    localparam int P_W      = 17;           // pressure word
    localparam int ALT_W    = 26;           // altitude word
    localparam int LOG_FRAC = 24;           // fraction bits of log2 / exp2
    localparam int LOG_W    = 29;           // Q.24 log2 of a 17-bit value

    localparam int LOG_LAT  = LOG_FRAC + 1; // normalise + one stage per bit
    localparam int EXP_LAT  = LOG_FRAC + 1; // one stage per bit + scale
    localparam int DIV_LAT  = 6;
    localparam int SCL_LAT  = 6;
    localparam int TOTAL_LAT = LOG_LAT + DIV_LAT + EXP_LAT + SCL_LAT;

    localparam logic [P_W-1:0] REF_RESET  = 17'd101325;
    localparam logic [P_W-1:0] MIN_SAMPLE = 17'd10;

    localparam int ALT_MIN_CM = -300000;
    localparam int ALT_MAX_CM = 22000000;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [29:0] HALF_Q30 = 30'h2000_0000;

    // y = L*1000/5257
    localparam int DIV_Y      = 5257;
    localparam int DIV_Y_HALF = DIV_Y / 2;
    localparam logic [26:0] Y_RECIP = 27'((64'd1 << 39) / 64'd5257);

    // h = d*57630000 / (13*2^30)
    localparam int ALT_SCALE = 57630000;
    localparam int ALT_DEN   = 13;
    localparam logic [43:0] H_HALF  = 44'(64'd13 << 29);
    localparam logic [27:0] H_RECIP = 28'((64'd1 << 31) / 64'd13);

    typedef struct packed {
        logic vld;
        logic low;   // sample below minimum
        logic zero;  // reference of zero
    } t_flags;

    function automatic logic [63:0] p2a_isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bitv;
        res  = '0;
        rem  = v;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q.30, by repeated square roots from 2.0
    function automatic logic [30:0] p2a_root_q30(input int k);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 1; i <= LOG_FRAC; i++) begin
            if (i <= k) begin
                r = p2a_isqrt(r << 30);
            end
        end
        return r[30:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/p2a_log2.sv
// ----------------------------------------------------------------------------
// p2a_log2
// Pipelined Q.24 log2 of a 17-bit word: normalise, then one squaring per bit.
// ----------------------------------------------------------------------------
`default_nettype none

module p2a_log2 (
    input  logic                        i_clk,
    input  logic [p2a_pkg::P_W-1:0]     i_x,
    output logic [p2a_pkg::LOG_W-1:0]   o_log
);
    import p2a_pkg::*;

    logic [30:0]      r_m [0:LOG_FRAC];
    logic [LOG_W-1:0] r_l [0:LOG_FRAC];

    logic [4:0]  w_n;
    logic [30:0] w_m0;

    // leading one
    always_comb begin
        w_n = '0;
        for (int i = 0; i < P_W; i++) begin
            if (i_x[i]) begin
                w_n = 5'(i);
            end
        end
        w_m0 = 31'(i_x) << (5'd30 - w_n);
    end

    always_ff @(posedge i_clk) begin
        r_m[0] <= w_m0;
        r_l[0] <= LOG_W'(w_n) << LOG_FRAC;
    end

    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_stage
        logic [61:0] w_sq;
        logic [31:0] w_t;
        assign w_sq = 62'(r_m[k-1]) * 62'(r_m[k-1]);
        assign w_t  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (w_t[31]) begin
                r_m[k] <= w_t[31:1];
                r_l[k] <= r_l[k-1] | (LOG_W'(1) << (LOG_FRAC - k));
            end else begin
                r_m[k] <= w_t[30:0];
                r_l[k] <= r_l[k-1];
            end
        end
    end

    assign o_log = r_l[LOG_FRAC];

endmodule

`default_nettype wire

// File: rtl/p2a_exp2.sv
// ----------------------------------------------------------------------------
// p2a_exp2
// Pipelined 2^y, y in Q.24, result in Q.30: one root product per fraction
// bit, then a scale by the integer part.
// ----------------------------------------------------------------------------
`default_nettype none

module p2a_exp2 (
    input  logic        i_clk,
    input  logic [26:0] i_y,
    output logic [33:0] o_e
);
    import p2a_pkg::*;

    logic [30:0]         r_m [1:LOG_FRAC];
    logic [LOG_FRAC-1:0] r_f [1:LOG_FRAC];
    logic [2:0]          r_n [1:LOG_FRAC];
    logic [33:0]         r_e;

    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_stage
        localparam logic [30:0] ROOT = p2a_root_q30(k);
        logic [30:0]         w_m_in;
        logic [LOG_FRAC-1:0] w_f_in;
        logic [2:0]          w_n_in;
        logic [62:0]         w_prod;
        if (k == 1) begin : g_first
            assign w_m_in = ONE_Q30;
            assign w_f_in = i_y[LOG_FRAC-1:0];
            assign w_n_in = i_y[26:24];
        end else begin : g_next
            assign w_m_in = r_m[k-1];
            assign w_f_in = r_f[k-1];
            assign w_n_in = r_n[k-1];
        end
        assign w_prod = 63'(w_m_in) * 63'(ROOT) + 63'(HALF_Q30);
        always_ff @(posedge i_clk) begin
            r_m[k] <= w_f_in[LOG_FRAC-k] ? w_prod[60:30] : w_m_in;
            r_f[k] <= w_f_in;
            r_n[k] <= w_n_in;
        end
    end

    // integer part: -4..3
    logic [2:0]  w_s;
    logic [33:0] w_sc;
    always_comb begin
        w_s = 3'd0 - r_n[LOG_FRAC];
        if (!r_n[LOG_FRAC][2]) begin
            w_sc = 34'(r_m[LOG_FRAC]) << r_n[LOG_FRAC][1:0];
        end else begin
            w_sc = (34'(r_m[LOG_FRAC]) + (34'd1 << (w_s - 3'd1))) >> w_s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= w_sc;
    end

    assign o_e = r_e;

endmodule

`default_nettype wire

// File: rtl/pressure_to_altitude_top.sv
// ----------------------------------------------------------------------------
// pressure_to_altitude_top
// Standard-day pressure altitude in centimetres from a static pressure word.
// ----------------------------------------------------------------------------
// A pressure word is taken on every clock at which start is high; busy never
// rises, so words may follow one another back to back. Each altitude word
// appears on o_altitude_cm for exactly one cycle with o_done high, once its
// pressure word has passed the 25-stage log2, the 6-stage divide by 5.257,
// the 25-stage exp2 and the 6-stage scaling. There is no back-pressure: the
// receiver must take the word in that cycle. Words leave in the order they
// came. The reference pressure register is written with i_ref_we and should
// only change while no word is in flight; it resets to 101325 Pa. A sample
// below 10 Pa gives 0 cm, a reference of zero gives the low limit, and all
// results saturate to -300000 .. 22000000 cm.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_to_altitude_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [p2a_pkg::P_W-1:0]            i_pressure_pa,
    output logic                               o_done,
    output logic signed [p2a_pkg::ALT_W-1:0]   o_altitude_cm,
    input  logic                               i_ref_we,
    input  logic [p2a_pkg::P_W-1:0]            i_reference_pressure_pa
);
    import p2a_pkg::*;

`include "pressure_to_altitude_top_defines.svh"

    localparam logic signed [28:0]      H_LO   = 29'(ALT_MIN_CM);
    localparam logic signed [28:0]      H_HI   = 29'(ALT_MAX_CM);
    localparam logic signed [ALT_W-1:0] ALT_LO = ALT_W'(ALT_MIN_CM);
    localparam logic signed [ALT_W-1:0] ALT_HI = ALT_W'(ALT_MAX_CM);

    // reference pressure register
    logic [P_W-1:0] r_ref;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RESET;
        end else if (i_ref_we) begin
            r_ref <= i_reference_pressure_pa;
        end
    end

    assign busy = 1'b0;

    // valid and special-case flags ride alongside the datapath
    t_flags r_flg [0:TOTAL_LAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                r_flg[i] <= '0;
            end
        end else begin
            r_flg[0] <= '{vld: start, low: (i_pressure_pa < MIN_SAMPLE),
                          zero: (r_ref == '0)};
            for (int i = 1; i < TOTAL_LAT; i++) begin
                r_flg[i] <= r_flg[i-1];
            end
        end
    end

    // -------- log2 of both pressures, in step --------
    logic [LOG_W-1:0] w_log_p;
    logic [LOG_W-1:0] w_log_ref;

    p2a_log2 u_log_p (
        .i_clk (i_clk),
        .i_x   (i_pressure_pa),
        .o_log (w_log_p)
    );

    p2a_log2 u_log_ref (
        .i_clk (i_clk),
        .i_x   (r_ref),
        .o_log (w_log_ref)
    );

    // -------- y = round(L*1000/5257) --------
    logic [29:0] r_ldiff;
    logic [38:0] r_num2, r_num3, r_num4;
    logic        r_neg2, r_neg3, r_neg4, r_neg5;
    logic [46:0] r_pl3;
    logic [26:0] r_qe4, r_qe5;
    logic [13:0] r_rem5;
    logic [26:0] r_y;

    logic [28:0] w_lmag;
    logic [46:0] w_ysum;
    logic [26:0] w_yq;

    always_comb begin
        w_lmag = r_ldiff[29] ? 29'(30'd0 - r_ldiff) : r_ldiff[28:0];
        w_ysum = 47'(r_num3[38:20]) * 47'(Y_RECIP) + (r_pl3 >> 20);
        w_yq   = r_qe5 + 27'(r_rem5 >= 14'(DIV_Y));
    end

    always_ff @(posedge i_clk) begin
        // T1: difference of logs
        r_ldiff <= 30'(w_log_ref) - 30'(w_log_p);
        // T2: magnitude times 1000, plus half divisor
        r_neg2  <= r_ldiff[29];
        r_num2  <= 39'(w_lmag) * 39'(1000) + 39'(DIV_Y_HALF);
        // T3: low partial product of the reciprocal
        r_pl3   <= 47'(r_num2[19:0]) * 47'(Y_RECIP);
        r_num3  <= r_num2;
        r_neg3  <= r_neg2;
        // T4: quotient estimate, at most one short
        r_qe4   <= w_ysum[45:19];
        r_num4  <= r_num3;
        r_neg4  <= r_neg3;
        // T5: remainder
        r_rem5  <= 14'(r_num4 - 39'(r_qe4) * 39'(DIV_Y));
        r_qe5   <= r_qe4;
        r_neg5  <= r_neg4;
        // T6: corrected and signed
        r_y     <= r_neg5 ? 27'd0 - w_yq : w_yq;
    end

    // -------- 2^y --------
    logic [33:0] w_e;

    p2a_exp2 u_exp (
        .i_clk (i_clk),
        .i_y   (r_y),
        .o_e   (w_e)
    );

    // -------- h = round(d*57630000 / (13*2^30)), saturated --------
    logic [34:0] w_d;
    logic [33:0] r_dmag;
    logic        r_dneg, r_neg8, r_neg9, r_neg10, r_neg11;
    logic [43:0] r_pl8;
    logic [16:0] r_dh8;
    logic [30:0] r_t9, r_t10;
    logic [27:0] r_qe10, r_qe11;
    logic [4:0]  r_rem11;
    logic [ALT_W-1:0] r_alt;

    logic [43:0] w_hsum;
    logic [58:0] w_hprod;
    logic [27:0] w_hq;
    logic signed [28:0] w_h;
    logic [ALT_W-1:0]   w_alt;
    t_flags             w_fl;

    always_comb begin
        w_d     = {1'b0, w_e} - (35'd1 << 30);
        w_hsum  = 44'(r_dh8) * 44'(ALT_SCALE) + (r_pl8 >> 17);
        w_hprod = 59'(r_t9) * 59'(H_RECIP);
        w_hq    = r_qe11 + 28'(r_rem11 >= 5'(ALT_DEN));
        w_h     = r_neg11 ? 29'd0 - 29'(w_hq) : 29'(w_hq);
        w_fl    = r_flg[TOTAL_LAT-2];
        if (w_fl.low) begin
            w_alt = '0;
        end else if (w_fl.zero || w_h < H_LO) begin
            w_alt = ALT_LO;
        end else if (w_h > H_HI) begin
            w_alt = ALT_HI;
        end else begin
            w_alt = w_h[ALT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        // T7: d = 2^y - 1, as sign and magnitude
        r_dneg  <= w_d[34];
        r_dmag  <= w_d[34] ? 34'(35'd0 - w_d) : w_d[33:0];
        // T8: low partial product plus rounding half
        r_pl8   <= 44'(r_dmag[16:0]) * 44'(ALT_SCALE) + H_HALF;
        r_dh8   <= r_dmag[33:17];
        r_neg8  <= r_dneg;
        // T9: floor of the product over 2^30
        r_t9    <= w_hsum[43:13];
        r_neg9  <= r_neg8;
        // T10: divide by 13, estimate
        r_qe10  <= w_hprod[58:31];
        r_t10   <= r_t9;
        r_neg10 <= r_neg9;
        // T11: remainder
        r_rem11 <= 5'(r_t10 - 31'(r_qe10) * 31'(ALT_DEN));
        r_qe11  <= r_qe10;
        r_neg11 <= r_neg10;
        // T12: sign, special cases, saturation
        r_alt   <= w_alt;
    end

    assign o_done        = r_flg[TOTAL_LAT-1].vld;
    assign o_altitude_cm = r_alt;

    `P2A_ASSERT_IMP(a_alt_range, o_done, (o_altitude_cm >= ALT_LO) && (o_altitude_cm <= ALT_HI))
    `P2A_ASSERT_IMP(a_low_sample, o_done && r_flg[TOTAL_LAT-1].low, o_altitude_cm == '0)
    `P2A_ASSERT_IMP(a_zero_ref, o_done && !r_flg[TOTAL_LAT-1].low && r_flg[TOTAL_LAT-1].zero, o_altitude_cm == ALT_LO)
    `P2A_ASSERT_NXT(a_ref_write, i_ref_we, r_ref == $past(i_reference_pressure_pa))

endmodule

`default_nettype wire
